/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the transcoder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/utt_pkg.sv */
// Types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by every module of the block.
`default_nettype none

package utt_pkg;

  localparam logic [15:0] UTT_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] UTT_HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] UTT_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] UTT_LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] UTT_REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] UTT_SUPP_BASE  = 21'h010000;

  // job queue between front and back
  localparam int UTT_QDEPTH = 4;
  localparam int UTT_QPTR_W = $clog2(UTT_QDEPTH);
  localparam int UTT_QCNT_W = $clog2(UTT_QDEPTH + 1);

  // replacement prefix is always three bytes
  localparam logic [2:0] UTT_REPL_LEN = 3'd3;

  typedef struct packed {
    logic        pre_repl;  // emit U+FFFD before the main code point
    logic        has_main;  // main code point present
    logic [20:0] cp;
  } utt_job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < 21'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (pos == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (pos)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (pos)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/utt_queue.sv */
// Short job queue decoupling the surrogate front end from the byte serializer.
// Depends on utt_pkg for the job type and depth.
`default_nettype none
`include "assert_macros.svh"

module utt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire utt_pkg::utt_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output utt_pkg::utt_job_t      head_job,
  output logic                   empty
);

  utt_pkg::utt_job_t mem_r [utt_pkg::UTT_QDEPTH];
  logic [utt_pkg::UTT_QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [utt_pkg::UTT_QCNT_W-1:0] count_r, count_nxt;

  localparam logic [utt_pkg::UTT_QCNT_W-1:0] DEPTH_C = utt_pkg::UTT_QCNT_W'(utt_pkg::UTT_QDEPTH);
  localparam logic [utt_pkg::UTT_QPTR_W-1:0] LAST_C  =
    utt_pkg::UTT_QPTR_W'(utt_pkg::UTT_QDEPTH - 1);

  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full && !pop, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "queue pop while empty")

endmodule

`default_nettype wire

/* hw/rtl/utt_front.sv */
// Front end: accepts UTF-16 words, pairs surrogates and queues encode jobs.
// Depends on utt_pkg for the job type and surrogate bounds.
`default_nettype none
`include "assert_macros.svh"

module utt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [15:0]       code_unit,
  input  wire logic              end_of_string,
  output logic                   push,
  output utt_pkg::utt_job_t      push_job
);

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_high_bits_r, held_high_bits_nxt;
  logic       is_high, is_low;

  assign is_high = (code_unit >= utt_pkg::UTT_HIGH_FIRST) && (code_unit <= utt_pkg::UTT_HIGH_LAST);
  assign is_low  = (code_unit >= utt_pkg::UTT_LOW_FIRST) && (code_unit <= utt_pkg::UTT_LOW_LAST);

  always_comb begin
    held_valid_nxt     = 1'b0;
    held_high_bits_nxt = 10'd0;
    push_job.pre_repl  = 1'b0;
    push_job.has_main  = 1'b0;
    push_job.cp        = {5'd0, code_unit};
    if (held_valid_r && is_low) begin
      push_job.has_main = 1'b1;
      push_job.cp       = {1'b0, held_high_bits_r, code_unit[9:0]} + utt_pkg::UTT_SUPP_BASE;
    end else begin
      // a broken pair is replaced, then the word is handled on its own
      push_job.pre_repl = held_valid_r;
      if (is_high) begin
        if (end_of_string) begin
          push_job.has_main = 1'b1;
          push_job.cp       = utt_pkg::UTT_REPL_CP;
        end else begin
          held_valid_nxt     = 1'b1;
          held_high_bits_nxt = code_unit[9:0];
        end
      end else if (is_low) begin
        push_job.has_main = 1'b1;
        push_job.cp       = utt_pkg::UTT_REPL_CP;
      end else begin
        push_job.has_main = 1'b1;
      end
    end
  end

  assign push = accept && (push_job.pre_repl || push_job.has_main);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r     <= 1'b0;
      held_high_bits_r <= 10'd0;
    end else if (accept) begin
      held_valid_r     <= held_valid_nxt;
      held_high_bits_r <= held_high_bits_nxt;
    end
  end

  `ASSERT_CLK(a_held_from_high,
    $rose(held_valid_r) |-> $past(accept && is_high && !end_of_string),
    "pending high surrogate without an accepted high word")

endmodule

`default_nettype wire

/* hw/rtl/utt_back.sv */
// Back end: serializes one queued job into UTF-8 bytes, one per cycle unless out_stall holds the output byte.
// Depends on utt_pkg for the job type and the encode helpers.
`default_nettype none
`include "assert_macros.svh"

module utt_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire utt_pkg::utt_job_t head_job,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_utf8_byte,
  output logic                   out_last_of_run
);

  logic [2:0] idx_r;
  logic [2:0] main_len, pre_len, total, main_pos;
  logic       slot_free, advance, is_last;
  logic [7:0] byte_val;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;

  assign main_len  = utt_pkg::utf8_len(head_job.cp);
  assign pre_len   = head_job.pre_repl ? utt_pkg::UTT_REPL_LEN : 3'd0;
  assign total     = pre_len + (head_job.has_main ? main_len : 3'd0);
  assign main_pos  = idx_r - pre_len;
  assign is_last   = (idx_r == total - 3'd1);
  assign slot_free = !out_valid_r || !out_stall;
  assign advance   = slot_free && !empty;
  assign pop       = advance && is_last;

  always_comb begin
    if (head_job.pre_repl && (idx_r < utt_pkg::UTT_REPL_LEN)) begin
      byte_val = utt_pkg::utf8_byte(utt_pkg::UTT_REPL_CP, utt_pkg::UTT_REPL_LEN, idx_r[1:0]);
    end else begin
      byte_val = utt_pkg::utf8_byte(head_job.cp, main_len, main_pos[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (slot_free) begin
        out_valid_r <= !empty;
      end
      if (advance) begin
        idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_val;
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_utf8_byte   = out_byte_r;
  assign out_last_of_run = out_last_r;

  `ASSERT_CLK(a_pop_marks_last, pop |=> (out_valid_r && out_last_r),
    "job retired without a last byte")
  `ASSERT_CLK(a_idx_cleared, (pop || empty) |=> (idx_r == 3'd0),
    "byte index not cleared between jobs")

endmodule

`default_nettype wire

/* hw/rtl/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder, top level.
// Instantiates utt_front, utt_queue and utt_back; uses utt_pkg.
//
// Input channel: in_valid/in_stall with in_code_unit and in_end_of_string;
// a word is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with out_utf8_byte and
// out_last_of_run, which marks the final byte released by one accepted word.
// A high surrogate waiting for its partner causes no bytes until the next
// word; unpaired surrogates come out as U+FFFD.
// The first byte of a word passes through the job queue and the output
// register before it is on the output. Throughput: one output byte per
// cycle while out_stall is low; a word yields 1 to 6 bytes (1-3 for a
// BMP word, 4 for a pair, plus 3 for a replaced pending surrogate). The
// front end takes one word per cycle while its 4-entry job queue has
// room; in_stall is high when the queue is full. When out_stall is high
// the held byte stays put and the queue fills behind it. Reset (rst_n low,
// synchronous) empties the queue, drops any pending high surrogate and
// clears out_valid.
`default_nettype none

module utf16_to_utf8_transcoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_end_of_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_utf8_byte,
  output logic             out_last_of_run
);

  utt_pkg::utt_job_t push_job, head_job;
  logic push, pop, q_full, q_empty, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  utt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .code_unit     (in_code_unit),
    .end_of_string (in_end_of_string),
    .push          (push),
    .push_job      (push_job)
  );

  utt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  utt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_utf8_byte   (out_utf8_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
